@@ hdl/mcf_pkg.sv @@
// Shared types, codes and CRC function of the memory command framer.
`default_nettype none
package mcf_pkg;

   localparam int BODY_BYTES = 5;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_DATA  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_LENGTH = 2'd1;
   localparam logic [1:0] ERR_SEQ    = 2'd2;

   localparam logic CSR_WRITE_CODE = 1'b0;
   localparam logic CSR_READ_CODE  = 1'b1;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] mem_address;
      logic [15:0] length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_of_frame;
      logic       last_of_run;
      logic [1:0] error;
   } rsp_type;

   // One classified transaction: the bytes it contributes and how to close it.
   typedef struct packed {
      logic [BODY_BYTES-1:0][7:0] body;
      logic [2:0]                 body_len;
      logic                       crc_init;
      logic                       crc_en;
      logic                       has_tail;
      logic [1:0]                 error;
   } cmd_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ hdl/mcf_front.sv @@
// Front end: accepts requests, tracks the open write, classifies into commands.
`default_nettype none
module mcf_front import mcf_pkg::*; #(
   parameter int MAX_WRITE_PAYLOAD = 58
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_index,
   input  wire logic [7:0] csr_data,
   input  wire logic    queue_full,
   output logic         push_valid,
   output cmd_type      push_cmd
);

   localparam int RW = $clog2(MAX_WRITE_PAYLOAD + 1);

   logic [7:0]    write_code_ff, read_code_ff;
   logic          wip_ff, wip_in;
   logic [RW-1:0] remain_ff, remain_in;
   logic          accept;
   logic [1:0]    seq_err;
   op_type        op;

   assign req_stall = queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_data.operation);
   assign seq_err   = wip_ff ? ERR_SEQ : ERR_NONE;

   always_comb begin
      wip_in     = wip_ff;
      remain_in  = remain_ff;
      push_valid = 1'b0;
      push_cmd   = '0;
      unique case (op)
         OP_READ: begin
            push_valid       = accept;
            push_cmd.body[0] = read_code_ff;
            push_cmd.body[1] = req_data.mem_address[15:8];
            push_cmd.body[2] = req_data.mem_address[7:0];
            push_cmd.body[3] = req_data.length[15:8];
            push_cmd.body[4] = req_data.length[7:0];
            push_cmd.body_len = 3'd5;
            push_cmd.crc_init = 1'b1;
            push_cmd.crc_en   = 1'b1;
            push_cmd.has_tail = 1'b1;
            push_cmd.error    = seq_err;
            wip_in    = 1'b0;
            remain_in = '0;
         end
         OP_WRITE: begin
            push_valid = accept;
            if (req_data.length > 16'(MAX_WRITE_PAYLOAD)) begin
               push_cmd.body_len = 3'd1;
               push_cmd.error    = ERR_LENGTH;
               wip_in    = 1'b0;
               remain_in = '0;
            end else begin
               push_cmd.body[0] = write_code_ff;
               push_cmd.body[1] = req_data.mem_address[15:8];
               push_cmd.body[2] = req_data.mem_address[7:0];
               push_cmd.body[3] = req_data.length[7:0];
               push_cmd.body_len = 3'd4;
               push_cmd.crc_init = 1'b1;
               push_cmd.crc_en   = 1'b1;
               push_cmd.has_tail = (req_data.length == 16'd0);
               push_cmd.error    = seq_err;
               wip_in    = (req_data.length != 16'd0);
               remain_in = req_data.length[RW-1:0];
            end
         end
         OP_DATA: begin
            push_valid        = accept;
            push_cmd.body_len = 3'd1;
            if (!wip_ff) begin
               push_cmd.error = ERR_SEQ;
            end else begin
               push_cmd.body[0]  = req_data.data_byte;
               push_cmd.crc_en   = 1'b1;
               push_cmd.has_tail = (remain_ff == RW'(1));
               remain_in = remain_ff - RW'(1);
               wip_in    = (remain_ff != RW'(1));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wip_ff        <= 1'b0;
         remain_ff     <= '0;
         write_code_ff <= 8'h00;
         read_code_ff  <= 8'h00;
      end else begin
         if (accept) begin
            wip_ff    <= wip_in;
            remain_ff <= remain_in;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WRITE_CODE) begin
               write_code_ff <= csr_data;
            end else begin
               read_code_ff <= csr_data;
            end
         end
      end
   end

endmodule
`default_nettype wire

@@ hdl/mcf_queue.sv @@
// Command queue between the front end and the byte sequencer.
`default_nettype none
module mcf_queue import mcf_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type       entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule
`default_nettype wire

@@ hdl/mcf_back.sv @@
// Back end: walks each command byte by byte, keeps the running CRC, drives results.
`default_nettype none
module mcf_back import mcf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire cmd_type head_cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic [2:0]  step_ff;
   logic [15:0] crc_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        adv, in_body, last;
   logic [2:0]  total, body_idx;
   logic [15:0] crc_base, crc_calc;
   logic [7:0]  body_byte;

   assign adv      = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign total    = head_cmd.body_len + (head_cmd.has_tail ? 3'd2 : 3'd0);
   assign last     = (step_ff == total - 3'd1);
   assign in_body  = (step_ff < head_cmd.body_len);
   assign body_idx = in_body ? step_ff : 3'd0;
   assign body_byte = head_cmd.body[body_idx];
   assign crc_base = (step_ff == 3'd0 && head_cmd.crc_init) ? CRC_INIT : crc_ff;
   assign crc_calc = crc16_byte(crc_base, body_byte);
   assign pop      = adv && last;

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.error       = head_cmd.error;
      rsp_data_in.last_of_run = last;
      if (in_body) begin
         rsp_data_in.frame_byte = body_byte;
      end else if (step_ff == head_cmd.body_len) begin
         rsp_data_in.frame_byte = crc_ff[7:0];
      end else begin
         rsp_data_in.frame_byte    = crc_ff[15:8];
         rsp_data_in.last_of_frame = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            step_ff <= last ? 3'd0 : step_ff + 3'd1;
            if (in_body && head_cmd.crc_en) begin
               crc_ff <= crc_calc;
            end
            rsp_data_ff <= rsp_data_in;
         end
         rsp_valid_ff <= adv || (rsp_valid_ff && rsp_stall);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ hdl/memory_command_framer_crc16.sv @@
// Top level of the memory command framer with CRC-16 trailer.
// A transaction's first frame byte passes a queue entry, then the result register.
// Throughput: one frame byte per cycle unless rsp_stall holds it; a read request
// yields 7 bytes, a write header 4 (6 at zero length), a payload byte 1 (3 if last).
// The front end accepts one transaction per cycle while the command queue has room.
// Reset is synchronous, active high: clears queue, open write, CRC and code registers.
`default_nettype none
module memory_command_framer_crc16 import mcf_pkg::*; #(
   parameter int MAX_WRITE_PAYLOAD = 58,
   parameter int QUEUE_DEPTH       = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_index,
   input  wire logic [7:0] csr_data
);

   logic    push_valid, queue_full, head_valid, pop;
   cmd_type push_cmd, head_cmd;

   mcf_front #(
      .MAX_WRITE_PAYLOAD(MAX_WRITE_PAYLOAD)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .queue_full(queue_full),
      .push_valid(push_valid),
      .push_cmd(push_cmd)
   );

   mcf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_cmd(push_cmd),
      .pop(pop),
      .full(queue_full),
      .head_valid(head_valid),
      .head_cmd(head_cmd)
   );

   mcf_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_cmd(head_cmd),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

@@ hdl/mcf_checker.sv @@
// Port-level checks of the memory command framer and their bind.
`default_nettype none
module mcf_checker import mcf_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_frame |-> rsp_data.last_of_run)
      else $error("frame closed before end of run");

   a_len_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error == ERR_LENGTH |->
         rsp_data.last_of_run && !rsp_data.last_of_frame && rsp_data.frame_byte == 8'h00)
      else $error("length error result malformed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("activity right after reset");

endmodule

bind memory_command_framer_crc16 mcf_checker u_mcf_checker (.*);
`default_nettype wire
